[design/ring_arc_quad_tessellator_top_macros.svh]
// Assertion macros for the ring arc quad tessellator.
// Uses clk and rst_n from the module that expands them.
`ifndef RING_ARC_QUAD_TESSELLATOR_TOP_MACROS_SVH
`define RING_ARC_QUAD_TESSELLATOR_TOP_MACROS_SVH

// same-cycle implication
`define RATC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ratc assertion failed");

// next-cycle implication
`define RATC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ratc assertion failed");

`endif

[design/ratc_pkg.sv]
// Shared types and constants of the ring arc quad tessellator.
// No dependencies.
package ratc_pkg;

  localparam int MIN_SEGMENTS_DEF = 3;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int ANG_W            = 25;
  localparam int RESULT_CAP       = 64;

  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [16:0] POLY_B = 17'd42048;
  localparam logic [16:0] POLY_C = 17'd4640;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        outer_radius;
    logic [15:0]        inner_radius;
    logic [16:0]        progress;
    logic [7:0]         segments;
    logic [6:0]         max_quads;
  } req_t;

  typedef struct packed {
    logic signed [15:0] inner_start_x;
    logic signed [15:0] inner_start_y;
    logic signed [15:0] outer_start_x;
    logic signed [15:0] outer_start_y;
    logic signed [15:0] outer_end_x;
    logic signed [15:0] outer_end_y;
    logic signed [15:0] inner_end_x;
    logic signed [15:0] inner_end_y;
    logic               quad_valid;
    logic               last;
  } quad_t;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        outer_radius;
    logic [15:0]        inner_radius;
    logic [ANG_W-1:0]   sweep;
    logic [ANG_W-1:0]   step_q;
    logic [6:0]         step_r;
    logic [6:0]         count;
    logic [6:0]         cap;
    logic               empty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/ratc_front.sv]
// Front end: accepts ring requests, clamps and classifies them and works out
// the angular step by a serial divider. Depends on ratc_pkg.
module ratc_front import ratc_pkg::*; #(
  parameter int MIN_SEGMENTS = MIN_SEGMENTS_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  req_t   in_data,
  input  qstat_t q_stat,
  output logic   q_push,
  output cmd_t   q_wdata
);

  localparam int AW = ANGLE_BITS + 1;
  localparam int CW = $clog2(ANGLE_BITS + 1);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  cmd_t          cmd_r;
  logic [CW-1:0] cnt_r;
  logic [6:0]    rem_r;
  logic [AW-1:0] quo_r;

  logic                 accept;
  logic [16:0]          prog_c;
  logic [6:0]           cap_c;
  logic [7:0]           seg_lo, seg_c;
  logic [16+ANGLE_BITS:0] sw_w;
  logic [AW-1:0]        sweep_c;
  logic                 empty_c;
  logic [7:0]           rs;
  logic                 ge;
  logic [7:0]           rs_sub;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_stat.full;

  always_comb begin
    q_wdata        = cmd_r;
    q_wdata.step_q = ANG_W'(quo_r);
    q_wdata.step_r = rem_r;
  end

  always_comb begin
    prog_c  = (in_data.progress > 17'd65536) ? 17'd65536 : in_data.progress;
    cap_c   = (in_data.max_quads > 7'(RESULT_CAP)) ? 7'(RESULT_CAP) : in_data.max_quads;
    seg_lo  = (in_data.segments < 8'(MIN_SEGMENTS)) ? 8'(MIN_SEGMENTS) : in_data.segments;
    seg_c   = (seg_lo > 8'(MAX_SEGMENTS)) ? 8'(MAX_SEGMENTS) : seg_lo;
    sw_w    = {prog_c, {ANGLE_BITS{1'b0}}} >> 16;
    sweep_c = sw_w[AW-1:0];
    empty_c = (sweep_c == '0) || (cap_c == 7'd0) ||
              (in_data.outer_radius <= in_data.inner_radius);
    rs      = {rem_r, (cnt_r == CW'(ANGLE_BITS))};
    ge      = (rs >= {1'b0, cmd_r.count});
    rs_sub  = rs - {1'b0, cmd_r.count};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = empty_c ? F_PUSH : F_DIV;
      F_DIV:  if (cnt_r == '0) state_nxt = F_PUSH;
      F_PUSH: if (!q_stat.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.center_x     <= in_data.center_x;
      cmd_r.center_y     <= in_data.center_y;
      cmd_r.outer_radius <= in_data.outer_radius;
      cmd_r.inner_radius <= in_data.inner_radius;
      cmd_r.sweep        <= ANG_W'(sweep_c);
      cmd_r.step_q       <= '0;
      cmd_r.step_r       <= '0;
      cmd_r.count        <= seg_c[6:0];
      cmd_r.cap          <= cap_c;
      cmd_r.empty        <= empty_c;
      cnt_r              <= CW'(ANGLE_BITS);
      rem_r              <= '0;
      quo_r              <= '0;
    end else if (state_r == F_DIV) begin
      rem_r <= ge ? rs_sub[6:0] : rs[6:0];
      quo_r <= {quo_r[AW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

[design/ratc_queue.sv]
// Two-entry command queue between front and back end.
// Depends on ratc_pkg.
module ratc_queue import ratc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   wdata,
  input  logic   pop,
  output cmd_t   rdata,
  output qstat_t stat
);

  cmd_t       ent0_r, ent1_r;
  logic [1:0] cnt_r;

  assign rdata      = ent0_r;
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        ent0_r <= wdata;
      end else begin
        ent0_r <= ent1_r;
        ent1_r <= wdata;
      end
    end else if (pop) begin
      ent0_r <= ent1_r;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        ent0_r <= wdata;
      end else begin
        ent1_r <= wdata;
      end
    end
  end

endmodule

[design/ratc_back.sv]
// Back end: steps through the ring segments, evaluates sines on one shared
// multiplier and scales the corners into an output register. Depends on ratc_pkg.
`include "ring_arc_quad_tessellator_top_macros.svh"
module ratc_back import ratc_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  qstat_t q_stat,
  input  cmd_t   q_data,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_stall,
  output quad_t  out_data
);

  localparam int AW = ANGLE_BITS + 1;
  localparam logic [AW-1:0] QTR = AW'(1) << (ANGLE_BITS - 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ANG  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_W1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_W2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_W3   = 4'd7;
  localparam logic [3:0] S_M4   = 4'd8;
  localparam logic [3:0] S_W4   = 4'd9;
  localparam logic [3:0] S_SM   = 4'd10;
  localparam logic [3:0] S_SW   = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  logic [3:0]          state_r, state_nxt;
  cmd_t                cmd_r;
  logic [6:0]          i_r, rem_r;
  logic [AW-1:0]       a0_r, an_r;
  logic [1:0]          k_r, quad_r;
  logic [2:0]          j_r;
  logic [15:0]         z_r, z2_r;
  logic [16:0]         t_r;
  logic signed [15:0]  s_r [4];
  logic signed [15:0]  c_r [8];
  logic signed [35:0]  p_r;
  logic                out_valid_r;
  quad_t               out_r;

  logic [AW-1:0]        sweep, stq, a1t, ang_b, ang, an_next;
  logic [ANGLE_BITS-3:0] frac;
  logic [ANGLE_BITS+12:0] zwide;
  logic [15:0]          z0;
  logic [16:0]          zr;
  logic [7:0]           rem_sum, rem_sub;
  logic                 carry, is_last, out_free, load;
  logic signed [17:0]   ma, mb;
  logic [17:0]          s_mag;
  logic [15:0]          s_cap;
  logic signed [15:0]   s_sgn, s_fin;
  logic signed [35:0]   off_w;
  logic signed [18:0]   v;
  logic signed [15:0]   v_sat;
  logic signed [15:0]   ctr;

  assign sweep = cmd_r.sweep[AW-1:0];
  assign stq   = cmd_r.step_q[AW-1:0];
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == S_EMIT) && out_free;
  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    a1t     = (an_r > sweep) ? sweep : an_r;
    ang_b   = k_r[1] ? a1t : a0_r;
    ang     = k_r[0] ? ang_b + QTR : ang_b;
    frac    = ang[ANGLE_BITS-3:0];
    zwide   = {frac, 15'b0};
    z0      = 16'(zwide >> (ANGLE_BITS - 2));
    zr      = ang[ANGLE_BITS-2] ? 17'd32768 - {1'b0, z0} : {1'b0, z0};
    rem_sum = {1'b0, rem_r} + {1'b0, cmd_r.step_r};
    carry   = (rem_sum >= {1'b0, cmd_r.count});
    rem_sub = rem_sum - {1'b0, cmd_r.count};
    an_next = an_r + stq + AW'(carry);
    is_last = (i_r + 7'd1 == cmd_r.count) || (i_r + 7'd1 == cmd_r.cap) ||
              (an_r >= sweep);
  end

  always_comb begin
    ma = $signed({2'b0, z_r});
    mb = $signed({2'b0, z_r});
    unique case (state_r)
      S_M2: begin
        ma = $signed({1'b0, POLY_C});
        mb = $signed({2'b0, z2_r});
      end
      S_M3: begin
        ma = $signed({2'b0, z2_r});
        mb = $signed({1'b0, t_r});
      end
      S_M4: mb = $signed({1'b0, t_r});
      S_SM: begin
        ma = (j_r[2] == j_r[1]) ? $signed({2'b0, cmd_r.inner_radius})
                                : $signed({2'b0, cmd_r.outer_radius});
        mb = 18'(s_r[{j_r[2], j_r[0]}]);
      end
      default: ;
    endcase
  end

  always_comb begin
    s_mag = p_r[33:16];
    s_cap = (s_mag > 18'd32767) ? 16'd32767 : s_mag[15:0];
    s_sgn = quad_r[1] ? -$signed(s_cap) : $signed(s_cap);
    s_fin = k_r[0] ? -s_sgn : s_sgn;
    off_w = (p_r + 36'sd16384) >>> 15;
    ctr   = j_r[0] ? cmd_r.center_y : cmd_r.center_x;
    v     = 19'(ctr) + off_w[18:0];
    if (v > 19'sd32767) begin
      v_sat = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      v_sat = -16'sh8000;
    end else begin
      v_sat = v[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_stat.empty) state_nxt = q_data.empty ? S_EMIT : S_ANG;
      S_ANG:  state_nxt = S_M1;
      S_M1:   state_nxt = S_W1;
      S_W1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_W2;
      S_W2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_W3;
      S_W3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_W4;
      S_W4:   state_nxt = (k_r == 2'd3) ? S_SM : S_ANG;
      S_SM:   state_nxt = S_SW;
      S_SW:   state_nxt = (j_r == 3'd7) ? S_EMIT : S_SM;
      S_EMIT: if (out_free) state_nxt = (cmd_r.empty || is_last) ? S_IDLE : S_ANG;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    unique case (state_r)
      S_IDLE: begin
        cmd_r <= q_data;
        i_r   <= '0;
        a0_r  <= '0;
        an_r  <= q_data.step_q[AW-1:0];
        rem_r <= q_data.step_r;
        k_r   <= '0;
        j_r   <= '0;
      end
      S_ANG: begin
        z_r    <= zr[15:0];
        quad_r <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
      end
      S_W1: z2_r <= p_r[30:15];
      S_W2: t_r  <= POLY_B - p_r[31:15];
      S_W3: t_r  <= POLY_A - p_r[31:15];
      S_W4: begin
        s_r[k_r] <= s_fin;
        k_r      <= k_r + 2'd1;
      end
      S_SW: begin
        c_r[j_r] <= v_sat;
        j_r      <= j_r + 3'd1;
      end
      S_EMIT: begin
        if (load) begin
          i_r   <= i_r + 7'd1;
          a0_r  <= an_r;
          an_r  <= an_next;
          rem_r <= carry ? rem_sub[6:0] : rem_sum[6:0];
          out_r.inner_start_x <= cmd_r.empty ? 16'sd0 : c_r[0];
          out_r.inner_start_y <= cmd_r.empty ? 16'sd0 : c_r[1];
          out_r.outer_start_x <= cmd_r.empty ? 16'sd0 : c_r[2];
          out_r.outer_start_y <= cmd_r.empty ? 16'sd0 : c_r[3];
          out_r.outer_end_x   <= cmd_r.empty ? 16'sd0 : c_r[4];
          out_r.outer_end_y   <= cmd_r.empty ? 16'sd0 : c_r[5];
          out_r.inner_end_x   <= cmd_r.empty ? 16'sd0 : c_r[6];
          out_r.inner_end_y   <= cmd_r.empty ? 16'sd0 : c_r[7];
          out_r.quad_valid    <= !cmd_r.empty;
          out_r.last          <= cmd_r.empty || is_last;
        end
      end
      default: ;
    endcase
  end

  `RATC_ASSERT_NOW(a_empty_is_last, out_valid_r && !out_r.quad_valid, out_r.last)
  `RATC_ASSERT_NOW(a_step_in_range, state_r == S_ANG, i_r < cmd_r.count && i_r < cmd_r.cap)
  `RATC_ASSERT_NOW(a_start_in_sweep, state_r == S_ANG, a0_r < sweep)
  `RATC_ASSERT_NEXT(a_pop_leaves_idle, q_pop, state_r != S_IDLE)

endmodule

[design/ring_arc_quad_tessellator_top.sv]
// Ring arc quad tessellator: cuts an annulus sector into quads.
// Uses ratc_pkg, ratc_front, ratc_queue and ratc_back.
//
// Usage: a request word enters on in_valid/in_stall/in_data; result words
// leave on out_valid/out_stall/out_data, one per quad, the final one with
// last set. An empty request (no sweep, no room, outer not above inner)
// yields one word with quad_valid clear and last set.
// Front end takes one request, runs the serial step divider on it (skipped
// for an empty request) and hands it to a two-entry queue, waiting while the
// queue is full; it takes the next request as soon as that hand-off is done.
// Back end works one quad at a time: four sine evaluations, each through the
// states S_ANG to S_W4, and eight corner scalings, each through S_SM and
// S_SW, all on one shared 18x18 multiplier, then a hand-off in S_EMIT.
// Results sit in an output register; a stalled receiver holds the word and
// the back end waits at the next hand-off. Synchronous reset clears the
// queue, both sequencers and out_valid.
module ring_arc_quad_tessellator_top import ratc_pkg::*; #(
  parameter int MIN_SEGMENTS = MIN_SEGMENTS_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  req_t  in_data,
  output logic  out_valid,
  input  logic  out_stall,
  output quad_t out_data
);

  qstat_t q_stat;
  logic   q_push, q_pop;
  cmd_t   q_wdata, q_rdata;

  ratc_front #(
    .MIN_SEGMENTS(MIN_SEGMENTS),
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  ratc_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  ratc_back #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[tb/tb_ring_arc_quad_tessellator_top.sv]
// Testbench for the ring arc quad tessellator: drives request words, predicts
// every quad in fixed point and checks each result word against it as a whole.
// Depends on ratc_pkg and ring_arc_quad_tessellator_top.
`timescale 1ns / 1ps

module tb_ring_arc_quad_tessellator_top;
  import ratc_pkg::*;

  localparam int MIN_SEG = MIN_SEGMENTS_DEF;
  localparam int MAX_SEG = MAX_SEGMENTS_DEF;
  localparam int ABITS   = ANGLE_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  req_t  in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  quad_t out_data;

  quad_t quads_due[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    timed_out = 1'b0;
  bit    calm = 1'b0;
  bit    hold_off = 1'b0;

  ring_arc_quad_tessellator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic longint sine_q15(longint ang);
    longint a, frac, z, z2, t, s;
    int quadrant;
    a = ang & ((64'd1 << ABITS) - 1);
    quadrant = int'((a >> (ABITS - 2)) & 3);
    frac = a & ((64'd1 << (ABITS - 2)) - 1);
    z = (ABITS >= 17) ? (frac >> (ABITS - 17)) : (frac << (17 - ABITS));
    if (quadrant[0]) z = 32768 - z;
    z2 = (z * z) >>> 15;
    t = (longint'(POLY_C) * z2) >>> 15;
    t = longint'(POLY_B) - t;
    t = (z2 * t) >>> 15;
    t = longint'(POLY_A) - t;
    s = (z * t) >>> 16;
    if (s > 32767) s = 32767;
    return quadrant[1] ? -s : s;
  endfunction

  function automatic logic [15:0] corner(logic signed [15:0] c, logic [15:0] r, longint s);
    longint p, v;
    p = longint'(r) * s;
    v = longint'(c) + ((p + 16384) >>> 15);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic tessellate(req_t rq);
    longint prog, sweep, a0, a1, quarter;
    longint sx0, sy0, sx1, sy1;
    int cap, cnt, n;
    quad_t q;
    prog = rq.progress > 65536 ? 65536 : rq.progress;
    cap = rq.max_quads > RESULT_CAP ? RESULT_CAP : rq.max_quads;
    sweep = (prog << ABITS) >> 16;
    quarter = 64'd1 << (ABITS - 2);
    if (sweep == 0 || cap == 0 || rq.outer_radius <= rq.inner_radius) begin
      q = '0;
      q.last = 1'b1;
      quads_due.push_back(q);
      return;
    end
    cnt = rq.segments;
    if (cnt < MIN_SEG) cnt = MIN_SEG;
    if (cnt > MAX_SEG) cnt = MAX_SEG;
    n = 0;
    for (int i = 0; i < cnt && n < cap; i++) begin
      a0 = (longint'(i) << ABITS) / cnt;
      a1 = (longint'(i + 1) << ABITS) / cnt;
      if (a0 >= sweep) break;
      if (a1 > sweep) a1 = sweep;
      sx0 = sine_q15(a0);
      sy0 = -sine_q15(a0 + quarter);
      sx1 = sine_q15(a1);
      sy1 = -sine_q15(a1 + quarter);
      q.inner_start_x = corner(rq.center_x, rq.inner_radius, sx0);
      q.inner_start_y = corner(rq.center_y, rq.inner_radius, sy0);
      q.outer_start_x = corner(rq.center_x, rq.outer_radius, sx0);
      q.outer_start_y = corner(rq.center_y, rq.outer_radius, sy0);
      q.outer_end_x   = corner(rq.center_x, rq.outer_radius, sx1);
      q.outer_end_y   = corner(rq.center_y, rq.outer_radius, sy1);
      q.inner_end_x   = corner(rq.center_x, rq.inner_radius, sx1);
      q.inner_end_y   = corner(rq.center_y, rq.inner_radius, sy1);
      q.quad_valid = 1'b1;
      q.last = 1'b0;
      quads_due.push_back(q);
      n++;
    end
    quads_due[$].last = 1'b1;
  endtask

  task automatic send_request(req_t rq);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tessellate(rq);
    @(negedge clk);
  endtask

  function automatic req_t rand_request();
    req_t rq;
    rq = req_t'({$urandom, $urandom, $urandom});
    rq.outer_radius = $urandom_range(20, 0) ? rq.outer_radius : rq.inner_radius;
    if ($urandom_range(9) > 1) begin
      rq.inner_radius = 16'($urandom_range(4000));
      rq.outer_radius = 16'(32'(rq.inner_radius) + $urandom_range(4000) + 1);
      if ($urandom_range(9) == 0) rq.outer_radius = 16'hffff;
      rq.progress = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
      rq.segments = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(12));
      rq.max_quads = $urandom_range(4) == 0 ? 7'($urandom) : 7'($urandom_range(8));
    end
    return rq;
  endfunction

  function automatic req_t make_req(int cx, int cy, int ro, int ri, int pr, int sg, int mq);
    req_t rq;
    rq.center_x = 16'(cx); rq.center_y = 16'(cy);
    rq.outer_radius = 16'(ro); rq.inner_radius = 16'(ri);
    rq.progress = 17'(pr); rq.segments = 8'(sg); rq.max_quads = 7'(mq);
    return rq;
  endfunction

  task automatic test_directed();
    send_request(make_req(0, 0, 100, 50, 0, 8, 8));
    send_request(make_req(0, 0, 100, 50, 1, 8, 8));
    send_request(make_req(0, 0, 100, 50, 65536, 8, 0));
    send_request(make_req(0, 0, 50, 50, 65536, 8, 8));
    send_request(make_req(0, 0, 40, 50, 65536, 8, 8));
    send_request(make_req(0, 0, 1600, 800, 65536, 0, 64));
    send_request(make_req(0, 0, 1600, 800, 65536, 255, 64));
    send_request(make_req(0, 0, 1600, 800, 131071, 64, 127));
    send_request(make_req(0, 0, 1600, 800, 40000, 12, 64));
    send_request(make_req(100, -100, 1600, 0, 65536, 16, 5));
    send_request(make_req(32767, 32767, 65535, 65534, 65536, 8, 8));
    send_request(make_req(-32768, -32768, 65535, 0, 65536, 8, 8));
    send_request(make_req(-1, 1, 65535, 32768, 49152, 4, 3));
    send_request(make_req(0, 0, 2, 1, 100, 3, 1));
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++)
      send_request(make_req(0, 0, 1600, 800, 65536, 4, 4));
  endtask

  task automatic test_random();
    for (int i = 0; i < 350; i++) begin
      calm = (i >= 150 && i < 200);
      send_request(rand_request());
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 32);
  end

  initial begin
    int held;
    wait (hold_off);
    held = 0;
    while (held < 2000) begin
      @(posedge clk);
      held++;
    end
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (quads_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        quad_t want;
        want = quads_due.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (quads_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && quads_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
